### design/bst_pkg.sv
// Shared types, sizes and codes for the bounded set table.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int ELEM_W   = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Index value that marks the end of a chain.
  localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(CAPACITY);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic signed [ELEM_W-1:0] element;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } res_item_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              val_we;
    logic [ADDR_W-1:0] val_addr;
    logic [ELEM_W-1:0] val_wdata;
    logic              link_we;
    logic [ADDR_W-1:0] link_addr;
    logic [IDX_W-1:0]  link_wdata;
  } store_req_t;

endpackage

`default_nettype wire

### design/bounded_set_table_core.sv
// Bounded set table top level: command channel, result register and slot store.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_item) takes one command item: insert,
//   remove or search of a 32-bit element. res channel (res_valid/res_ready/
//   res_item) returns exactly one result item per command: status, element
//   count after the command and an empty flag.
//   One command is in work at a time. After acceptance the occupied chain is
//   walked one slot per cycle out of the slot memories (one read port), at most
//   CAPACITY slots per command; an insert or remove that changes the set then
//   passes through its update states (S_INS_A/S_INS_B or S_REM_A/S_REM_B)
//   before its result reaches the result register.
//   After reset the block rebuilds the free chain in the link memory and
//   holds cmd_ready low meanwhile; the set starts empty.
//   The result register decouples the receiver: while res_valid waits on
//   res_ready the next command is taken and walked; it only holds at its end
//   until the register frees up.

module bounded_set_table_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire bst_pkg::cmd_item_t    cmd_item,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output bst_pkg::res_item_t         res_item
);
  import bst_pkg::*;

  store_req_t        req;
  logic [ELEM_W-1:0] rd_val;
  logic [IDX_W-1:0]  rd_link;
  logic              done_valid;
  logic              done_ready;
  res_item_t         done_item;

  bst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_item   (cmd_item),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_item  (done_item),
    .req        (req),
    .rd_val     (rd_val),
    .rd_link    (rd_link)
  );

  bst_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_val  (rd_val),
    .rd_link (rd_link)
  );

  // Load a new result whenever the register is empty or being drained.
  assign done_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_ready) begin
      res_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      res_item <= done_item;
    end
  end

endmodule

`default_nettype wire

### design/bst_store.sv
// Slot value and link memories, one read and one write per memory each cycle.
`timescale 1ns / 1ps
`default_nettype none

module bst_store (
  input  wire logic                     clk,
  input  wire bst_pkg::store_req_t      req,
  output logic [bst_pkg::ELEM_W-1:0]    rd_val,
  output logic [bst_pkg::IDX_W-1:0]     rd_link
);
  import bst_pkg::*;

  logic [ELEM_W-1:0] val_mem  [CAPACITY];
  logic [IDX_W-1:0]  link_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.val_we) begin
      val_mem[req.val_addr] <= req.val_wdata;
    end
    if (req.rd_en) begin
      rd_val <= val_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_addr] <= req.link_wdata;
    end
    if (req.rd_en) begin
      rd_link <= link_mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/bst_ctrl.sv
// Command sequencer: chain walk, insert and remove updates, free chain build pass.
`timescale 1ns / 1ps
`default_nettype none

module bst_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cmd_valid,
  output logic                         cmd_ready,
  input  wire bst_pkg::cmd_item_t      cmd_item,
  output logic                         done_valid,
  input  wire logic                    done_ready,
  output bst_pkg::res_item_t           done_item,
  output bst_pkg::store_req_t          req,
  input  wire logic [bst_pkg::ELEM_W-1:0] rd_val,
  input  wire logic [bst_pkg::IDX_W-1:0]  rd_link
);
  import bst_pkg::*;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_WALK   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_INS_A  = 8'b0001_0000,
    S_INS_B  = 8'b0010_0000,
    S_REM_A  = 8'b0100_0000,
    S_REM_B  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic                done_pend;
  logic [CMD_W-1:0]    cmd_r;
  logic [ELEM_W-1:0]   elem_r;
  logic [IDX_W-1:0]    cur;
  logic [IDX_W-1:0]    prev;
  logic [IDX_W-1:0]    steps;
  logic [IDX_W-1:0]    steps_next;
  logic                found;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    hit_prev;
  logic [IDX_W-1:0]    hit_after;
  logic [IDX_W-1:0]    free_head;
  logic [IDX_W-1:0]    list_head;
  logic [IDX_W-1:0]    list_tail;
  logic [IDX_W-1:0]    held_count;
  logic [IDX_W-1:0]    init_idx;
  logic [STATUS_W-1:0] status_r;
  logic                accept;
  logic                match;
  logic                walk_more;

  assign cmd_ready  = (state == S_IDLE) && !done_pend;
  assign accept     = cmd_valid && cmd_ready;
  assign match      = (rd_val == elem_r);
  assign steps_next = steps + IDX_W'(1);
  assign walk_more  = (rd_link < NONE_IDX) && (steps_next < NONE_IDX);

  assign done_valid         = done_pend;
  assign done_item.status   = status_r;
  assign done_item.count    = COUNT_W'(held_count);
  assign done_item.is_empty = (held_count == '0);

  // Memory requests and next state.
  always_comb begin
    req            = '0;
    req.val_wdata  = elem_r;
    req.val_addr   = free_head[ADDR_W-1:0];
    state_next     = state;
    unique case (state)
      S_INIT: begin
        req.link_we    = 1'b1;
        req.link_addr  = init_idx[ADDR_W-1:0];
        req.link_wdata = init_idx + IDX_W'(1);
        if (init_idx == NONE_IDX - IDX_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req.rd_en   = 1'b1;
          req.rd_addr = list_head[ADDR_W-1:0];
          state_next  = (list_head < NONE_IDX) ? S_WALK : S_DECIDE;
        end
      end
      S_WALK: begin
        if (!match && walk_more) begin
          req.rd_en   = 1'b1;
          req.rd_addr = rd_link[ADDR_W-1:0];
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (cmd_r == CMD_INSERT && !found && free_head < NONE_IDX) begin
          state_next = S_INS_A;
        end else if (cmd_r == CMD_REMOVE && found) begin
          state_next = S_REM_A;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_INS_A: begin
        // Fetch the free successor, store the value, hook onto the old tail.
        req.rd_en      = 1'b1;
        req.rd_addr    = free_head[ADDR_W-1:0];
        req.val_we     = 1'b1;
        req.link_we    = (list_tail < NONE_IDX);
        req.link_addr  = list_tail[ADDR_W-1:0];
        req.link_wdata = free_head;
        state_next     = S_INS_B;
      end
      S_INS_B: begin
        req.link_we    = 1'b1;
        req.link_addr  = free_head[ADDR_W-1:0];
        req.link_wdata = NONE_IDX;
        state_next     = S_IDLE;
      end
      S_REM_A: begin
        req.link_we    = (hit_prev < NONE_IDX);
        req.link_addr  = hit_prev[ADDR_W-1:0];
        req.link_wdata = hit_after;
        state_next     = S_REM_B;
      end
      S_REM_B: begin
        req.link_we    = 1'b1;
        req.link_addr  = hit_idx[ADDR_W-1:0];
        req.link_wdata = free_head;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      done_pend  <= 1'b0;
      init_idx   <= '0;
      free_head  <= '0;
      list_head  <= NONE_IDX;
      list_tail  <= NONE_IDX;
      held_count <= '0;
    end else begin
      state <= state_next;
      if (done_pend && done_ready) begin
        done_pend <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          init_idx <= init_idx + IDX_W'(1);
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r  <= cmd_item.cmd;
            elem_r <= cmd_item.element;
            cur    <= list_head;
            prev   <= NONE_IDX;
            steps  <= '0;
            found  <= 1'b0;
          end
        end
        S_WALK: begin
          if (match) begin
            found     <= 1'b1;
            hit_idx   <= cur;
            hit_prev  <= prev;
            hit_after <= rd_link;
          end else if (walk_more) begin
            prev  <= cur;
            cur   <= rd_link;
            steps <= steps_next;
          end
        end
        S_DECIDE: begin
          priority if (cmd_r == CMD_INSERT) begin
            if (found) begin
              status_r  <= ST_MISS;
              done_pend <= 1'b1;
            end else if (free_head >= NONE_IDX) begin
              status_r  <= ST_FULL;
              done_pend <= 1'b1;
            end
          end else if (cmd_r == CMD_REMOVE) begin
            if (!found) begin
              status_r  <= ST_MISS;
              done_pend <= 1'b1;
            end
          end else if (cmd_r == CMD_SEARCH) begin
            status_r  <= found ? ST_OK : ST_MISS;
            done_pend <= 1'b1;
          end else begin
            status_r  <= ST_MISS;
            done_pend <= 1'b1;
          end
        end
        S_INS_A: begin
          if (list_head >= NONE_IDX) begin
            list_head <= free_head;
          end
          list_tail  <= free_head;
          held_count <= held_count + IDX_W'(1);
        end
        S_INS_B: begin
          free_head <= rd_link;
          status_r  <= ST_OK;
          done_pend <= 1'b1;
        end
        S_REM_A: begin
          if (hit_prev >= NONE_IDX) begin
            list_head <= hit_after;
          end
          if (hit_idx == list_tail) begin
            list_tail <= hit_prev;
          end
        end
        S_REM_B: begin
          free_head <= hit_idx;
          if (held_count != '0) begin
            held_count <= held_count - IDX_W'(1);
          end
          status_r  <= ST_OK;
          done_pend <= 1'b1;
        end
        default: begin
          init_idx <= '0;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= NONE_IDX)
    else $error("held count above capacity");

  a_head_vs_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((list_head >= NONE_IDX) == (held_count == '0)))
    else $error("list head and count disagree");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (steps < NONE_IDX))
    else $error("chain walk ran past capacity");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_A) |-> (free_head < NONE_IDX && !found))
    else $error("insert without a free slot");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM_B) |=> (held_count == $past(held_count) - IDX_W'(1)))
    else $error("remove did not drop the count");
`endif

endmodule

`default_nettype wire
